>>> src/crt_controller_register_block_core_macros.svh
// Assertion macros for the CRT controller register block.
// Used by the top level only; no other dependencies.
`ifndef CRT_CONTROLLER_REGISTER_BLOCK_CORE_MACROS_SVH
`define CRT_CONTROLLER_REGISTER_BLOCK_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset
`define CRTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crtc assertion failed");
// Next-cycle implication, checked outside reset
`define CRTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crtc assertion failed");
`else
`define CRTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CRTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> src/crtc_pkg.sv
// Types, codes and constants for the CRT controller register block.
// No dependencies; imported by crt_controller_register_block_core.
package crtc_pkg;

    // Item kinds
    localparam logic [2:0] KIND_INDEX_WR = 3'd0;
    localparam logic [2:0] KIND_DATA_WR  = 3'd1;
    localparam logic [2:0] KIND_DATA_RD  = 3'd2;
    localparam logic [2:0] KIND_SCAN     = 3'd3;
    localparam logic [2:0] KIND_FIELD    = 3'd4;

    // Register indexes with a decoded meaning
    localparam logic [4:0] REG_HTOTAL    = 5'd0;
    localparam logic [4:0] REG_MODE      = 5'd8;
    localparam logic [4:0] REG_CUR_START = 5'd10;
    localparam logic [4:0] REG_CUR_END   = 5'd11;
    localparam logic [4:0] REG_START_HI  = 5'd12;
    localparam logic [4:0] REG_START_LO  = 5'd13;
    localparam logic [4:0] REG_CUR_HI    = 5'd14;
    localparam logic [4:0] REG_CUR_LO    = 5'd15;

    // Write masks
    localparam logic [7:0] MASK_MODE  = 8'h03;
    localparam logic [7:0] MASK_5BIT  = 8'h1f;
    localparam logic [7:0] MASK_6BIT  = 8'h3f;
    localparam logic [7:0] MASK_7BIT  = 8'h7f;
    localparam logic [7:0] REG_RESET  = 8'hff;

    // Cursor modes, R10 bits 6:5
    localparam logic [1:0] CUR_STEADY     = 2'b00;
    localparam logic [1:0] CUR_OFF        = 2'b01;
    localparam logic [1:0] CUR_BLINK_FAST = 2'b10;
    localparam logic [1:0] CUR_BLINK_SLOW = 2'b11;

    localparam logic [5:0] BLINK_FAST = 6'd16;
    localparam logic [5:0] BLINK_SLOW = 6'd32;

    // Configuration register indexes
    localparam logic [2:0] CFG_SCAN_PERIOD  = 3'd0;
    localparam logic [2:0] CFG_BLANK_THRESH = 3'd1;
    localparam logic [2:0] CFG_FIELD_PERIOD = 3'd2;
    localparam logic [2:0] CFG_EN_INVERT    = 3'd3;
    localparam logic [2:0] CFG_FORCE_IL     = 3'd4;

    localparam logic [15:0] SCAN_PERIOD_RST  = 16'd100;
    localparam logic [15:0] BLANK_THRESH_RST = 16'd20;
    localparam logic [23:0] FIELD_PERIOD_RST = 24'd10000;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        display_enable;
        logic        cursor_enabled;
        logic        cursor_phase;
        logic [13:0] start_address;
        logic [13:0] cursor_address;
        logic [3:0]  cursor_first_line;
        logic [3:0]  cursor_last_line;
        logic        interlace;
        logic [1:0]  line_repeat;
        logic [8:0]  total_columns;
        logic        field_end;
    } t_out_item;

    // Scan line number clamped to 15
    function automatic logic [3:0] clamp15(input logic [4:0] v);
        return v[4] ? 4'd15 : v[3:0];
    endfunction

endpackage

>>> src/crt_controller_register_block_core.sv
// CRT controller register file and timing counters.
// Each accepted item's result is registered in the output stage; throughput one item per cycle while the skid is empty.
// A two-entry output stage (result register plus skid) keeps input ready registered.
// Reset (synchronous, active low) loads power-on register values and config defaults.
// Depends on crtc_pkg and crt_controller_register_block_core_macros.svh.
`include "crt_controller_register_block_core_macros.svh"

module crt_controller_register_block_core
    import crtc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item
);

    // Configuration
    logic [15:0] r_scan_period;
    logic [15:0] r_blank_thresh;
    logic [23:0] r_field_period;
    logic        r_en_invert;
    logic        r_force_il;

    // Register file entries that affect behaviour (others are write-only)
    logic [7:0]  r_r10, r_r11, r_r12, r_r13, r_r14, r_r15;
    logic [7:0]  n_r10, n_r11, n_r12, n_r13, n_r14, n_r15;

    // Decoded and timing state
    logic [4:0]  r_sel, n_sel;
    logic [15:0] r_line_cnt, n_line_cnt;
    logic [23:0] r_field_cnt, n_field_cnt;
    logic [5:0]  r_blink_cnt, n_blink_cnt;
    logic [5:0]  r_blink_rel, n_blink_rel;
    logic        r_cur_on, n_cur_on;
    logic        r_cur_blinks, n_cur_blinks;
    logic        r_cur_phase, n_cur_phase;
    logic [13:0] r_start, n_start;
    logic [13:0] r_cur_addr, n_cur_addr;
    logic [3:0]  r_cur_first, n_cur_first;
    logic [3:0]  r_cur_last, n_cur_last;
    logic        r_interlace, n_interlace;
    logic        r_rep1, n_rep1;
    logic [8:0]  r_htotal, n_htotal;

    // Output stage
    logic        r_out_valid;
    logic        r_skid_valid;
    t_out_item   r_out;
    t_out_item   r_skid;
    t_out_item   n_res;

    logic        accept;
    logic        out_free;
    logic [7:0]  v;
    logic [7:0]  vm;

    assign o_in_ready  = !r_skid_valid;
    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign v           = i_in_item.data_value;

    // Next state and result for one item
    always_comb begin
        n_sel       = r_sel;
        n_line_cnt  = r_line_cnt;
        n_field_cnt = r_field_cnt;
        n_blink_cnt = r_blink_cnt;
        n_blink_rel = r_blink_rel;
        n_cur_on    = r_cur_on;
        n_cur_blinks = r_cur_blinks;
        n_cur_phase = r_cur_phase;
        n_start     = r_start;
        n_cur_addr  = r_cur_addr;
        n_cur_first = r_cur_first;
        n_cur_last  = r_cur_last;
        n_interlace = r_interlace;
        n_rep1      = r_rep1;
        n_htotal    = r_htotal;
        n_r10 = r_r10; n_r11 = r_r11; n_r12 = r_r12;
        n_r13 = r_r13; n_r14 = r_r14; n_r15 = r_r15;
        vm    = v;
        n_res = '0;

        case (i_in_item.kind)
            KIND_INDEX_WR: begin
                n_sel = v[4:0];
            end
            KIND_DATA_WR: begin
                case (r_sel)
                    REG_HTOTAL: begin
                        n_htotal = {1'b0, v} + 9'd1;
                    end
                    REG_MODE: begin
                        vm          = v & MASK_MODE;
                        n_interlace = vm[0] | r_force_il;
                        n_rep1      = (vm[1:0] == 2'd3);
                    end
                    REG_CUR_START: begin
                        vm    = v & MASK_7BIT;
                        n_r10 = vm;
                        if (vm != r_r10) begin
                            n_cur_first = clamp15(vm[4:0]);
                            case (vm[6:5])
                                CUR_STEADY: begin
                                    n_cur_on     = 1'b1;
                                    n_cur_blinks = 1'b0;
                                    n_blink_rel  = BLINK_FAST;
                                    n_cur_phase  = 1'b1;
                                end
                                CUR_OFF: begin
                                    n_cur_on = 1'b0;
                                end
                                CUR_BLINK_FAST: begin
                                    n_cur_on     = 1'b1;
                                    n_cur_blinks = 1'b1;
                                    n_blink_rel  = BLINK_FAST;
                                end
                                default: begin
                                    n_cur_on     = 1'b1;
                                    n_cur_blinks = 1'b1;
                                    n_blink_rel  = BLINK_SLOW;
                                end
                            endcase
                        end
                    end
                    REG_CUR_END: begin
                        vm    = v & MASK_5BIT;
                        n_r11 = vm;
                        if (vm != r_r11) n_cur_last = clamp15(vm[4:0]);
                    end
                    REG_START_HI: begin
                        vm    = v & MASK_6BIT;
                        n_r12 = vm;
                        if (vm != r_r12) n_start[13:8] = vm[5:0];
                    end
                    REG_START_LO: begin
                        n_r13 = v;
                        if (v != r_r13) n_start[7:0] = v;
                    end
                    REG_CUR_HI: begin
                        vm    = v & MASK_6BIT;
                        n_r14 = vm;
                        if (vm != r_r14) n_cur_addr[13:8] = vm[5:0];
                    end
                    REG_CUR_LO: begin
                        n_r15 = v;
                        if (v != r_r15) n_cur_addr[7:0] = v;
                    end
                    default: ;
                endcase
            end
            KIND_DATA_RD: begin
                if (r_sel == REG_CUR_HI)      n_res.read_data = r_r14;
                else if (r_sel == REG_CUR_LO) n_res.read_data = r_r15;
            end
            KIND_SCAN: begin
                if (r_line_cnt > 16'd1) n_line_cnt = r_line_cnt - 16'd1;
                else                    n_line_cnt = r_scan_period;
            end
            KIND_FIELD: begin
                if (r_field_cnt > 24'd1) begin
                    n_field_cnt = r_field_cnt - 24'd1;
                end else begin
                    n_field_cnt     = r_field_period;
                    n_res.field_end = 1'b1;
                    if (r_blink_cnt > 6'd1) begin
                        n_blink_cnt = r_blink_cnt - 6'd1;
                    end else begin
                        n_blink_cnt = r_blink_rel;
                        if (r_cur_on && r_cur_blinks) n_cur_phase = !r_cur_phase;
                    end
                end
            end
            default: ;
        endcase

        // Result shows the state after this item
        n_res.display_enable    = (n_line_cnt >= r_blank_thresh) ^ r_en_invert;
        n_res.cursor_enabled    = n_cur_on;
        n_res.cursor_phase      = n_cur_phase;
        n_res.start_address     = n_start;
        n_res.cursor_address    = n_cur_addr;
        n_res.cursor_first_line = n_cur_first;
        n_res.cursor_last_line  = n_cur_last;
        n_res.interlace         = n_interlace;
        n_res.line_repeat       = n_rep1 ? 2'd1 : 2'd2;
        n_res.total_columns     = n_htotal;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_period  <= SCAN_PERIOD_RST;
            r_blank_thresh <= BLANK_THRESH_RST;
            r_field_period <= FIELD_PERIOD_RST;
            r_en_invert    <= 1'b0;
            r_force_il     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCAN_PERIOD:  r_scan_period  <= i_cfg_data[15:0];
                CFG_BLANK_THRESH: r_blank_thresh <= i_cfg_data[15:0];
                CFG_FIELD_PERIOD: r_field_period <= i_cfg_data;
                CFG_EN_INVERT:    r_en_invert    <= i_cfg_data[0];
                CFG_FORCE_IL:     r_force_il     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // State update on accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel        <= '0;
            r_line_cnt   <= SCAN_PERIOD_RST;
            r_field_cnt  <= FIELD_PERIOD_RST;
            r_blink_cnt  <= BLINK_FAST;
            r_blink_rel  <= BLINK_FAST;
            r_cur_on     <= 1'b0;
            r_cur_blinks <= 1'b1;
            r_cur_phase  <= 1'b0;
            r_start      <= '0;
            r_cur_addr   <= '0;
            r_cur_first  <= '0;
            r_cur_last   <= '0;
            r_interlace  <= 1'b0;
            r_rep1       <= 1'b0;
            r_htotal     <= '0;
            r_r10 <= REG_RESET; r_r11 <= REG_RESET; r_r12 <= REG_RESET;
            r_r13 <= REG_RESET; r_r14 <= REG_RESET; r_r15 <= REG_RESET;
        end else if (accept) begin
            r_sel        <= n_sel;
            r_line_cnt   <= n_line_cnt;
            r_field_cnt  <= n_field_cnt;
            r_blink_cnt  <= n_blink_cnt;
            r_blink_rel  <= n_blink_rel;
            r_cur_on     <= n_cur_on;
            r_cur_blinks <= n_cur_blinks;
            r_cur_phase  <= n_cur_phase;
            r_start      <= n_start;
            r_cur_addr   <= n_cur_addr;
            r_cur_first  <= n_cur_first;
            r_cur_last   <= n_cur_last;
            r_interlace  <= n_interlace;
            r_rep1       <= n_rep1;
            r_htotal     <= n_htotal;
            r_r10 <= n_r10; r_r11 <= n_r11; r_r12 <= n_r12;
            r_r13 <= n_r13; r_r14 <= n_r14; r_r15 <= n_r15;
        end
    end

    // Output stage: result register with a skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) r_out <= r_skid;
            else if (accept)  r_out <= n_res;
        end else if (accept) begin
            r_skid <= n_res;
        end
    end

    // Checks
    `CRTC_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `CRTC_ASSERT_NXT(a_stall_fills_skid, i_clk, i_rst_n,
        accept && r_out_valid && !i_out_ready, r_skid_valid)
    `CRTC_ASSERT_IMP(a_steady_phase, i_clk, i_rst_n, !r_cur_blinks, r_cur_phase)
    `CRTC_ASSERT_IMP(a_blink_range, i_clk, i_rst_n, 1'b1,
        (r_blink_cnt != 6'd0) && (r_blink_cnt <= BLINK_SLOW))

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the CRT controller register block: a shadow copy of the
// register file and timing counters predicts every result. Depends on crtc_pkg and the RTL.
module tb_top
    import crtc_pkg::*;
();

    // Registers without a decoded meaning, masked on write (R31 keeps all bits)
    localparam logic [4:0] REG_SYNC_WIDTH = 5'd3;
    localparam logic [4:0] REG_VTOTAL     = 5'd4;
    localparam logic [4:0] REG_VTOTAL_ADJ = 5'd5;
    localparam logic [4:0] REG_VDISP      = 5'd6;
    localparam logic [4:0] REG_VSYNC_POS  = 5'd7;
    localparam logic [4:0] REG_MAX_SCAN   = 5'd9;
    localparam logic [4:0] REG_TOP        = 5'd31;
    localparam logic [7:0] MASK_4BIT      = 8'h0f;
    localparam logic [7:0] MASK_ALL       = 8'hff;

    // Shadow of the CRTC state; predicts one result per item and holds the
    // results still owed by the block
    class crtc_shadow;
        logic [7:0]  regs [32];
        logic [4:0]  reg_sel;
        logic [15:0] line_cnt;
        logic [23:0] field_cnt;
        logic [5:0]  blink_cnt;
        logic [5:0]  blink_rel;
        logic        cur_on;
        logic        cur_blinks;
        logic        cur_phase;
        logic [13:0] start_addr;
        logic [13:0] cur_addr;
        logic [7:0]  cur_lines;
        logic [1:0]  mode;
        logic [8:0]  htotal;
        // configuration copy
        logic [15:0] scan_period;
        logic [15:0] blank_thr;
        logic [23:0] field_period;
        logic        invert;
        logic        force_il;
        t_out_item   owed_results [$];
        int unsigned errors;

        function new();
            foreach (regs[i]) regs[i] = REG_RESET;
            reg_sel      = '0;
            scan_period  = SCAN_PERIOD_RST;
            blank_thr    = BLANK_THRESH_RST;
            field_period = FIELD_PERIOD_RST;
            invert       = 1'b0;
            force_il     = 1'b0;
            line_cnt     = SCAN_PERIOD_RST;
            field_cnt    = FIELD_PERIOD_RST;
            blink_cnt    = BLINK_FAST;
            blink_rel    = BLINK_FAST;
            cur_on       = 1'b0;
            cur_blinks   = 1'b1;
            cur_phase    = 1'b0;
            start_addr   = '0;
            cur_addr     = '0;
            cur_lines    = '0;
            mode         = '0;
            htotal       = '0;
            errors       = 0;
        endfunction

        function void set_config(logic [2:0] idx, logic [23:0] val);
            case (idx)
                CFG_SCAN_PERIOD:  scan_period  = val[15:0];
                CFG_BLANK_THRESH: blank_thr    = val[15:0];
                CFG_FIELD_PERIOD: field_period = val;
                CFG_EN_INVERT:    invert       = val[0];
                CFG_FORCE_IL:     force_il     = val[0];
                default: ;
            endcase
        endfunction

        function logic [7:0] write_mask(logic [4:0] sel);
            case (sel)
                REG_SYNC_WIDTH:                 return MASK_4BIT;
                REG_VTOTAL, REG_VDISP,
                REG_VSYNC_POS, REG_CUR_START:   return MASK_7BIT;
                REG_VTOTAL_ADJ, REG_MAX_SCAN,
                REG_CUR_END:                    return MASK_5BIT;
                REG_MODE:                       return MASK_MODE;
                REG_START_HI, REG_CUR_HI:       return MASK_6BIT;
                default:                        return MASK_ALL;
            endcase
        endfunction

        function logic [3:0] line_limit(logic [4:0] v);
            return (v > 5'd15) ? 4'd15 : v[3:0];
        endfunction

        // Data write: mask, decode (R10..R15 only when the value changes, R0 and R8 always), store
        function void write_data(logic [7:0] v);
            logic [7:0] m;
            logic       changed;
            m       = v & write_mask(reg_sel);
            changed = (m != regs[reg_sel]);
            case (reg_sel)
                REG_HTOTAL: htotal = {1'b0, v} + 9'd1;
                REG_MODE:   mode = {m == MASK_MODE, m[0] | force_il};
                REG_CUR_START: if (changed) begin
                    cur_lines[3:0] = line_limit(m[4:0]);
                    case (m[6:5])
                        CUR_STEADY: begin
                            cur_on = 1'b1; cur_blinks = 1'b0;
                            blink_rel = BLINK_FAST; cur_phase = 1'b1;
                        end
                        CUR_OFF: cur_on = 1'b0;
                        CUR_BLINK_FAST: begin
                            cur_on = 1'b1; cur_blinks = 1'b1; blink_rel = BLINK_FAST;
                        end
                        default: begin
                            cur_on = 1'b1; cur_blinks = 1'b1; blink_rel = BLINK_SLOW;
                        end
                    endcase
                end
                REG_CUR_END:  if (changed) cur_lines[7:4] = line_limit(m[4:0]);
                REG_START_HI: if (changed) start_addr[13:8] = m[5:0];
                REG_START_LO: if (changed) start_addr[7:0] = m;
                REG_CUR_HI:   if (changed) cur_addr[13:8] = m[5:0];
                REG_CUR_LO:   if (changed) cur_addr[7:0] = m;
                default: ;
            endcase
            regs[reg_sel] = m;
        endfunction

        // Advance the shadow by one item and form the result it causes
        function t_out_item advance(t_in_item it);
            t_out_item r;
            logic [7:0] rd;
            logic       fend;
            rd   = '0;
            fend = 1'b0;
            case (it.kind)
                KIND_INDEX_WR: reg_sel = it.data_value[4:0];
                KIND_DATA_WR:  write_data(it.data_value);
                KIND_DATA_RD:  if (reg_sel == REG_CUR_HI || reg_sel == REG_CUR_LO)
                                   rd = regs[reg_sel];
                KIND_SCAN:     if (line_cnt > 16'd1) line_cnt = line_cnt - 16'd1;
                               else line_cnt = scan_period;
                KIND_FIELD: begin
                    if (field_cnt > 24'd1) begin
                        field_cnt = field_cnt - 24'd1;
                    end else begin
                        field_cnt = field_period;
                        fend = 1'b1;
                        if (blink_cnt > 6'd1) begin
                            blink_cnt = blink_cnt - 6'd1;
                        end else begin
                            blink_cnt = blink_rel;
                            if (cur_on && cur_blinks) cur_phase = !cur_phase;
                        end
                    end
                end
                default: ;
            endcase
            r.read_data         = rd;
            r.display_enable    = (line_cnt >= blank_thr) ^ invert;
            r.cursor_enabled    = cur_on;
            r.cursor_phase      = cur_phase;
            r.start_address     = start_addr;
            r.cursor_address    = cur_addr;
            r.cursor_first_line = cur_lines[3:0];
            r.cursor_last_line  = cur_lines[7:4];
            r.interlace         = mode[0];
            r.line_repeat       = mode[1] ? 2'd1 : 2'd2;
            r.total_columns     = htotal;
            r.field_end         = fend;
            return r;
        endfunction

        function void note_item(t_in_item it);
            owed_results.push_back(advance(it));
        endfunction

        function void cmp(string fld, logic [15:0] e, logic [15:0] a);
            if (a !== e) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, fld, e, a);
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (owed_results.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result %h", $time, got);
                return;
            end
            e = owed_results.pop_front();
            cmp("read_data",         16'(e.read_data),         16'(got.read_data));
            cmp("display_enable",    16'(e.display_enable),    16'(got.display_enable));
            cmp("cursor_enabled",    16'(e.cursor_enabled),    16'(got.cursor_enabled));
            cmp("cursor_phase",      16'(e.cursor_phase),      16'(got.cursor_phase));
            cmp("start_address",     16'(e.start_address),     16'(got.start_address));
            cmp("cursor_address",    16'(e.cursor_address),    16'(got.cursor_address));
            cmp("cursor_first_line", 16'(e.cursor_first_line), 16'(got.cursor_first_line));
            cmp("cursor_last_line",  16'(e.cursor_last_line),  16'(got.cursor_last_line));
            cmp("interlace",         16'(e.interlace),         16'(got.interlace));
            cmp("line_repeat",       16'(e.line_repeat),       16'(got.line_repeat));
            cmp("total_columns",     16'(e.total_columns),     16'(got.total_columns));
            cmp("field_end",         16'(e.field_end),         16'(got.field_end));
        endfunction

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [2:0]  cfg_index   = '0;
    logic [23:0] cfg_data    = '0;
    logic        in_valid    = 1'b0;
    t_in_item    in_item     = '0;
    logic        out_ready   = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    t_out_item   o_out_item;

    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    logic        hold_req      = 1'b0;
    logic        holding       = 1'b0;
    crtc_shadow  shadow        = new();

    crt_controller_register_block_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    // Result side: random stalls, or a long hold-off when asked
    always @(posedge i_clk) begin
        out_ready <= holding ? 1'b0 : ($urandom_range(99) >= stall_pct);
    end

    // Long receiver hold-off, counted here so the sender keeps pushing
    always @(posedge hold_req) begin
        @(posedge i_clk);
        holding <= 1'b1;
        repeat (150) @(posedge i_clk);
        holding <= 1'b0;
    end

    // Monitor: check results, note accepted items
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && out_ready) shadow.check_result(o_out_item);
            if (in_valid && o_in_ready) shadow.note_item(in_item);
        end
    end

    // Offer one item after a random gap and wait for it to be taken
    task automatic push_item(input t_in_item it);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send(input logic [2:0] k, input logic [7:0] d);
        t_in_item it;
        it.kind       = k;
        it.data_value = d;
        push_item(it);
    endtask

    // Stop offering and wait for every owed result; the first edge lets the
    // monitor note the last accepted item
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (shadow.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Write all five registers while the block is idle
    task automatic configure(input logic [15:0] sp, input logic [15:0] bt,
                             input logic [23:0] fp, input logic inv, input logic fil);
        logic [23:0] vals [5];
        vals[CFG_SCAN_PERIOD]  = {8'd0, sp};
        vals[CFG_BLANK_THRESH] = {8'd0, bt};
        vals[CFG_FIELD_PERIOD] = fp;
        vals[CFG_EN_INVERT]    = {23'd0, inv};
        vals[CFG_FORCE_IL]     = {23'd0, fil};
        for (int i = 0; i < 5; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= vals[i];
            @(posedge i_clk);
            shadow.set_config(3'(i), vals[i]);
        end
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random item, weighted towards decoded registers and ticks
    function automatic t_in_item rand_item();
        t_in_item    it;
        int unsigned r;
        int unsigned pick;
        r  = $urandom_range(99);
        it.data_value = 8'($urandom);
        if (r < 12) begin
            it.kind = KIND_INDEX_WR;
            pick = $urandom_range(9);
            case (pick)
                0: it.data_value[4:0] = REG_HTOTAL;
                1: it.data_value[4:0] = REG_MODE;
                2: it.data_value[4:0] = REG_CUR_START;
                3: it.data_value[4:0] = REG_CUR_END;
                4: it.data_value[4:0] = REG_START_HI;
                5: it.data_value[4:0] = REG_START_LO;
                6: it.data_value[4:0] = REG_CUR_HI;
                7: it.data_value[4:0] = REG_CUR_LO;
                default: ;
            endcase
        end else if (r < 40) begin
            it.kind = KIND_DATA_WR;
            if ($urandom_range(7) == 0) it.data_value = $urandom_range(1) ? MASK_ALL : 8'h00;
        end else if (r < 50) begin
            it.kind = KIND_DATA_RD;
        end else if (r < 70) begin
            it.kind = KIND_SCAN;
        end else if (r < 97) begin
            it.kind = KIND_FIELD;
        end else begin
            it.kind = 3'($urandom_range(KIND_FIELD + 1, 7));
        end
        return it;
    endfunction

    task automatic run_random(input int n, input int idle_pct, input int stall);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        repeat (n) push_item(rand_item());
        drain();
    endtask

    // Watchdog
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: reset state, decode only on change, cursor modes, clamping
        send(KIND_DATA_RD, 8'h00);              // total columns still 0
        send(KIND_INDEX_WR, {3'b111, REG_START_LO});
        send(KIND_DATA_WR, 8'hff);              // same as reset value: no decode
        send(KIND_INDEX_WR, 8'(REG_CUR_LO));
        send(KIND_DATA_WR, 8'hff);
        send(KIND_DATA_RD, 8'hff);              // reads R15
        send(KIND_INDEX_WR, 8'(REG_HTOTAL));
        send(KIND_DATA_WR, 8'hff);              // 256 columns
        send(KIND_DATA_WR, 8'h00);
        send(KIND_INDEX_WR, 8'(REG_MODE));
        send(KIND_DATA_WR, 8'hff);              // interlace, single line
        send(KIND_INDEX_WR, 8'(REG_CUR_START));
        send(KIND_DATA_WR, 8'h1f);              // steady, first line clamped
        send(KIND_DATA_WR, 8'h3f);              // off
        send(KIND_DATA_WR, 8'h4a);              // fast blink
        send(KIND_DATA_WR, 8'hff);              // slow blink
        send(KIND_INDEX_WR, 8'(REG_CUR_END));
        send(KIND_DATA_WR, 8'hff);
        send(KIND_INDEX_WR, 8'(REG_CUR_HI));
        send(KIND_DATA_WR, 8'haa);
        send(KIND_DATA_RD, 8'h00);
        send(KIND_INDEX_WR, 8'(REG_TOP));
        send(KIND_DATA_RD, 8'hff);              // unreadable register
        send(KIND_SCAN, 8'hff);
        send(KIND_FIELD, 8'h00);
        send(3'(KIND_FIELD + 1), 8'hff);        // unused kinds
        send(3'(KIND_FIELD + 3), 8'h5a);
        drain();

        // Shortest periods, inverted enable, forced interlace; sender idles
        configure(16'd1, 16'd0, 24'd1, 1'b1, 1'b1);
        run_random(120, 68, 0);

        // Longest periods and highest threshold; receiver stalls
        configure(16'hffff, 16'hffff, 24'hffffff, 1'b0, 1'b0);
        run_random(80, 0, 68);

        // Receiver holds off while the sender keeps offering items
        configure(16'd7, 16'd4, 24'd2, 1'b0, 1'b1);
        hold_req = 1'b1;
        run_random(40, 0, 0);
        run_random(110, 9, 9);

        configure(16'd13, 16'd6, 24'd1, 1'b1, 1'b0);
        run_random(120, 0, 0);

        configure(16'd3, 16'd2, 24'd3, 1'b0, 1'b1);
        run_random(110, 0, 68);

        repeat (4) @(posedge i_clk);
        if (shadow.errors == 0 && shadow.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
